// File: sv/rhat_pkg.sv
// ----------------------------------------------------------------------------
// rhat_pkg: shared types and constants for the refcounted hash accounting table
// Holds the table geometry, result codes, total widths and the slot hash.
// ----------------------------------------------------------------------------
package rhat_pkg;

  // Table geometry. Slot count is a power of two so the hash reduces to a slice.
  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int USED_BITS   = SLOT_BITS + 1;

  // A charge is skipped once used + 1 would reach three quarters of the slots.
  localparam int FULL_USED = (TABLE_SLOTS * 3 + 3) / 4 - 1;

  // Golden-ratio multiplier. Only its low SLOT_BITS bits reach the slot index.
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  // Field and accumulator widths.
  localparam int KEY_IN_BITS = 48;
  localparam int LEN_BITS    = 32;
  localparam int CHARGED_W   = 48;
  localparam int DEBT_W      = 34;
  localparam int WORK_SHIFT  = 10;
  localparam int WORK_W      = 23;
  localparam int STATUS_W    = 3;

  typedef logic [SLOT_BITS-1:0] slot_idx_t;
  typedef logic [STATUS_W-1:0]  status_t;

  // Result codes.
  localparam status_t ST_NEW     = 3'd0;
  localparam status_t ST_RAISED  = 3'd1;
  localparam status_t ST_LOWERED = 3'd2;
  localparam status_t ST_REMOVED = 3'd3;
  localparam status_t ST_IGNORED = 3'd4;
  localparam status_t ST_FULL    = 3'd5;

  // Request types.
  localparam logic REQ_CHARGE    = 1'b0;
  localparam logic REQ_DISCHARGE = 1'b1;

  // Home slot of a key. The low bits of ((key >> 4) * HASH_MULT) depend only on
  // key bits [SLOT_BITS+3:4] and the low bits of the multiplier.
  function automatic slot_idx_t home_of(input logic [SLOT_BITS-1:0] kbits);
    logic [2*SLOT_BITS-1:0] prod;
    prod = {{SLOT_BITS{1'b0}}, kbits} * {{SLOT_BITS{1'b0}}, HASH_MULT[SLOT_BITS-1:0]};
    return prod[SLOT_BITS-1:0];
  endfunction

endpackage

// File: sv/refcounted_hash_accounting_table.sv
// ----------------------------------------------------------------------------
// refcounted_hash_accounting_table: reference-counted block accounting table
// Open-addressing hash table with linear probing and backward-shift deletion.
// ----------------------------------------------------------------------------
// A charge skipped at the load limit is answered from idle; any other request probes from
// its home slot. A new entry or an ignored discharge is decided at a free slot, a raised or
// lowered count on a key hit, and a removal after a backward shift over the occupied slots.
// Each probe costs a valid check plus a key/count memory read.
// Throughput: one request at a time; busy falls with the result beat, which cannot stall.
// Reset clears every valid bit at once, zeroes the totals and sets step_threshold to 1048576.
module refcounted_hash_accounting_table
  import rhat_pkg::*;
#(
  parameter int KEY_BITS   = 48,
  parameter int COUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // Request beat.
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type,
  input  logic [KEY_IN_BITS-1:0] block_key,
  input  logic [LEN_BITS-1:0]    block_length,
  // Result beat, one cycle wide.
  output logic                   done,
  output status_t                status,
  output logic                   step_request,
  output logic [WORK_W-1:0]      step_work,
  output logic [CHARGED_W-1:0]   charged_total,
  // Threshold write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_data
);

  // Stored key width: the key port is masked down to KEY_BITS.
  localparam int KW    = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
  localparam int ENT_W = KW + COUNT_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
  localparam logic [2:0] S_PROBE = 3'd1;  // check valid bit, issue key read
  localparam logic [2:0] S_CMP   = 3'd2;  // compare key read back, act on a hit
  localparam logic [2:0] S_SHCHK = 3'd3;  // backward shift: check next slot
  localparam logic [2:0] S_SHCMP = 3'd4;  // backward shift: decide on a move

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  // Control registers.
  logic [2:0]           state, state_next;
  slot_idx_t            idx, idx_next;
  slot_idx_t            hole, hole_next;
  slot_idx_t            nxt, nxt_next;
  logic [TABLE_SLOTS-1:0] slot_valid, slot_valid_next;
  logic [USED_BITS-1:0] used_slots, used_slots_next;
  logic [CHARGED_W-1:0] charged_bytes, charged_bytes_next;
  logic [DEBT_W-1:0]    pending_debt, pending_debt_next;
  logic [31:0]          step_threshold;
  logic                 done_next;

  // Request payload held for the duration of the item.
  logic                 req_q;
  logic [KW-1:0]        key_q;
  logic [LEN_BITS-1:0]  len_q;

  // Result payload.
  status_t              status_next;
  logic                 step_request_next;
  logic [WORK_W-1:0]    step_work_next;
  logic [CHARGED_W-1:0] charged_total_next;

  // Key/count memory: one write port, one registered read port.
  logic [ENT_W-1:0] slot_mem [TABLE_SLOTS];
  logic             mem_we;
  slot_idx_t        wr_addr;
  slot_idx_t        rd_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data;

  logic [KW-1:0]         rd_key;
  logic [COUNT_BITS-1:0] rd_count;
  logic [COUNT_BITS-1:0] count_dec;
  logic                  key_hit;

  // Charge and credit arithmetic on the running totals.
  logic [CHARGED_W:0]   charged_sum;
  logic [CHARGED_W-1:0] charged_add;
  logic [CHARGED_W-1:0] charged_sub;
  logic [CHARGED_W-1:0] len_wide;
  logic [DEBT_W:0]      debt_sum;
  logic [DEBT_W-1:0]    debt_add;
  logic [DEBT_W-1:0]    debt_sub;
  logic [DEBT_W-1:0]    len_debt;
  logic                 step_hit;

  // Backward-shift distances, modulo the table size by wraparound.
  slot_idx_t rd_home;
  slot_idx_t d_home;
  slot_idx_t d_hole;

  logic table_full;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign rd_key   = rd_data[ENT_W-1:COUNT_BITS];
  assign rd_count = rd_data[COUNT_BITS-1:0];
  assign key_hit  = (rd_key == key_q);
  assign count_dec = (rd_count != '0) ? rd_count - COUNT_ONE : rd_count;

  assign len_wide    = {{(CHARGED_W-LEN_BITS){1'b0}}, len_q};
  assign len_debt    = {{(DEBT_W-LEN_BITS){1'b0}}, len_q};
  assign charged_sum = {1'b0, charged_bytes} + {1'b0, len_wide};
  assign charged_add = charged_sum[CHARGED_W] ? {CHARGED_W{1'b1}} : charged_sum[CHARGED_W-1:0];
  assign charged_sub = (len_wide <= charged_bytes) ? charged_bytes - len_wide : '0;
  assign debt_sum    = {1'b0, pending_debt} + {1'b0, len_debt};
  assign debt_add    = debt_sum[DEBT_W] ? {DEBT_W{1'b1}} : debt_sum[DEBT_W-1:0];
  assign debt_sub    = (len_debt <= pending_debt) ? pending_debt - len_debt : '0;
  assign step_hit    = (debt_add >= {{(DEBT_W-32){1'b0}}, step_threshold});

  assign rd_home = home_of(rd_key[SLOT_BITS+3:4]);
  assign d_home  = nxt - rd_home;
  assign d_hole  = nxt - hole;

  // The load check uses the count before the item, as does the table limit.
  assign table_full = (used_slots >= USED_BITS'(FULL_USED));

  // The read port follows the probe index, or the shift cursor while shifting.
  assign rd_addr = (state == S_SHCHK) ? nxt : idx;

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    hole_next          = hole;
    nxt_next           = nxt;
    slot_valid_next    = slot_valid;
    used_slots_next    = used_slots;
    charged_bytes_next = charged_bytes;
    pending_debt_next  = pending_debt;
    done_next          = 1'b0;
    status_next        = status;
    step_request_next  = 1'b0;
    step_work_next     = '0;
    charged_total_next = charged_total;
    mem_we             = 1'b0;
    wr_addr            = idx;
    wr_data            = {key_q, rd_count};

    unique case (state)
      S_IDLE: begin
        if (start) begin
          // A charge over the load limit is skipped before any lookup.
          if ((req_type == REQ_CHARGE) && table_full) begin
            done_next          = 1'b1;
            status_next        = ST_FULL;
            charged_total_next = charged_bytes;
          end else begin
            idx_next   = home_of(block_key[SLOT_BITS+3:4]);
            state_next = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (!slot_valid[idx]) begin
          // Free slot on the probe path: the key is not in the table.
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (req_q == REQ_CHARGE) begin
            mem_we                = 1'b1;
            wr_data               = {key_q, COUNT_ONE};
            slot_valid_next[idx]  = 1'b1;
            used_slots_next       = used_slots + USED_BITS'(1);
            charged_bytes_next    = charged_add;
            charged_total_next    = charged_add;
            status_next           = ST_NEW;
            if (step_hit) begin
              // The debt is paid in full by the step request.
              step_request_next = 1'b1;
              step_work_next    = debt_add[WORK_SHIFT+WORK_W-1:WORK_SHIFT];
              pending_debt_next = '0;
            end else begin
              pending_debt_next = debt_add;
            end
          end else begin
            status_next        = ST_IGNORED;
            charged_total_next = charged_bytes;
          end
        end else begin
          state_next = S_CMP;
        end
      end

      S_CMP: begin
        if (!key_hit) begin
          idx_next   = idx + SLOT_BITS'(1);
          state_next = S_PROBE;
        end else if (req_q == REQ_CHARGE) begin
          // Existing key: the count saturates at its maximum.
          mem_we             = 1'b1;
          wr_data            = {key_q, (rd_count != COUNT_MAX) ? rd_count + COUNT_ONE
                                                               : rd_count};
          state_next         = S_IDLE;
          done_next          = 1'b1;
          status_next        = ST_RAISED;
          charged_total_next = charged_bytes;
        end else if (count_dec != '0) begin
          mem_we             = 1'b1;
          wr_data            = {key_q, count_dec};
          state_next         = S_IDLE;
          done_next          = 1'b1;
          status_next        = ST_LOWERED;
          charged_total_next = charged_bytes;
        end else begin
          // Last handle dropped: credit the length back and open the hole.
          if (used_slots != '0) begin
            used_slots_next = used_slots - USED_BITS'(1);
          end
          charged_bytes_next = charged_sub;
          pending_debt_next  = debt_sub;
          hole_next          = idx;
          nxt_next           = idx + SLOT_BITS'(1);
          state_next         = S_SHCHK;
        end
      end

      S_SHCHK: begin
        if (!slot_valid[nxt]) begin
          // End of the cluster: the hole becomes a free slot.
          slot_valid_next[hole] = 1'b0;
          state_next            = S_IDLE;
          done_next             = 1'b1;
          status_next           = ST_REMOVED;
          charged_total_next    = charged_bytes;
        end else begin
          state_next = S_SHCMP;
        end
      end

      S_SHCMP: begin
        // An entry moves back only if the hole lies on its own probe path.
        if (d_home >= d_hole) begin
          mem_we    = 1'b1;
          wr_addr   = hole;
          wr_data   = rd_data;
          hole_next = nxt;
        end
        nxt_next   = nxt + SLOT_BITS'(1);
        state_next = S_SHCHK;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slot_valid     <= '0;
      used_slots     <= '0;
      charged_bytes  <= '0;
      pending_debt   <= '0;
      step_threshold <= 32'd1048576;
      done           <= 1'b0;
    end else begin
      state         <= state_next;
      slot_valid    <= slot_valid_next;
      used_slots    <= used_slots_next;
      charged_bytes <= charged_bytes_next;
      pending_debt  <= pending_debt_next;
      done          <= done_next;
      if (cfg_valid && cfg_ready) begin
        step_threshold <= cfg_data;
      end
    end
  end

  // Payload and cursor registers need no reset.
  always_ff @(posedge clk) begin
    idx           <= idx_next;
    hole          <= hole_next;
    nxt           <= nxt_next;
    status        <= status_next;
    step_request  <= step_request_next;
    step_work     <= step_work_next;
    charged_total <= charged_total_next;
    if (start && !busy) begin
      req_q <= req_type;
      key_q <= block_key[KW-1:0];
      len_q <= block_length;
    end
  end

  // Key/count memory. A read that meets a write to the same slot returns the
  // old entry; that only happens on a step whose read data the next state ignores.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data <= slot_mem[rd_addr];
  end

endmodule

// File: tb/refcounted_hash_accounting_table_test.sv
// ----------------------------------------------------------------------------
// refcounted_hash_accounting_table_test: self-checking bench for the table
// Sends charge and discharge beats, keeps its own copy of the hash table and
// totals, and checks every result beat field by field against that copy.
// ----------------------------------------------------------------------------
module refcounted_hash_accounting_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rhat_pkg::*;

  // Cycles of calm the sender waits, once nothing is outstanding, before it
  // writes the threshold or ends a pause.
  localparam int QUIET_CYCLES = 4;
  // After the last result, wait about one full probe plus one full
  // backward-shift walk so that a stray beat would still be seen.
  localparam int END_CYCLES = 1100;
  // Multiplicative inverse of the hash multiplier's low byte (0xB1) modulo
  // 256. It lets the stimulus pick keys whose home slot is known.
  localparam int HOME_INVERSE = 81;
  localparam longint unsigned CHARGED_CAP = (64'd1 << CHARGED_W) - 64'd1;
  localparam longint unsigned DEBT_CAP    = (64'd1 << DEBT_W) - 64'd1;
  localparam logic [31:0] THRESHOLD_AT_RESET = 32'd1048576;

  typedef enum logic [1:0] {
    PLAN_ITEM,
    PLAN_SET_THRESHOLD,
    PLAN_HOLD
  } plan_kind_t;

  typedef struct {
    plan_kind_t             kind;
    logic                   req;
    logic [KEY_IN_BITS-1:0] key;
    logic [LEN_BITS-1:0]    len;
    logic [31:0]            value;
  } plan_entry_t;

  typedef struct {
    status_t              status;
    logic                 step_request;
    logic [WORK_W-1:0]    step_work;
    logic [CHARGED_W-1:0] charged_total;
  } acct_result_t;

  // Block ports. Every input has a known value from time zero.
  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   start        = 1'b0;
  logic                   req_type     = 1'b0;
  logic [KEY_IN_BITS-1:0] block_key    = '0;
  logic [LEN_BITS-1:0]    block_length = '0;
  logic                   cfg_valid    = 1'b0;
  logic [31:0]            cfg_data     = '0;
  logic                   busy;
  logic                   done;
  status_t                status;
  logic                   step_request;
  logic [WORK_W-1:0]      step_work;
  logic [CHARGED_W-1:0]   charged_total;
  logic                   cfg_ready;

  refcounted_hash_accounting_table uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work still to be sent, and results still to arrive, oldest first.
  plan_entry_t  request_plan[$];
  acct_result_t outcomes_due[$];

  // Shadow of the table, the totals and the threshold register.
  logic                   slot_live [TABLE_SLOTS] = '{default: 1'b0};
  logic [KEY_IN_BITS-1:0] slot_tag  [TABLE_SLOTS];
  logic [31:0]            slot_refs [TABLE_SLOTS];
  int                     live_count = 0;
  longint unsigned        charged_sum = 0;
  longint unsigned        debt_sum = 0;
  logic [31:0]            step_threshold_now = THRESHOLD_AT_RESET;

  // Key pool that the random part draws from.
  logic [KEY_IN_BITS-1:0] key_pool[$];

  // Driver and monitor bookkeeping.
  int          error_count = 0;
  int          beats_taken = 0;
  int          gap_left = 0;
  int          quiet_count = 0;
  logic        hold_start;
  logic        hold_cfg;
  plan_entry_t next_step;
  acct_result_t want;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Shadow model of the table.
  // ---------------------------------------------------------------------------

  // Home slot: ((key >> 4) * 2654435761) mod 2^64, reduced to the slot count.
  function automatic int slot_home(input logic [KEY_IN_BITS-1:0] key);
    longint unsigned prod;
    prod = {16'd0, key} >> 4;
    prod = prod * 64'd2654435761;
    return int'(prod % TABLE_SLOTS);
  endfunction

  // Slot holding the key, or the first free slot on its probe path.
  function automatic int locate(input logic [KEY_IN_BITS-1:0] key);
    int idx;
    idx = slot_home(key);
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!slot_live[idx] || slot_tag[idx] == key) return idx;
      idx = (idx + 1) % TABLE_SLOTS;
    end
    return idx;
  endfunction

  // Backward-shift deletion: pull later entries of the cluster into the hole
  // whenever doing so does not move them ahead of their home slot.
  task automatic evict(input int slot);
    int hole;
    int nxt;
    int home;
    int d_home;
    int d_hole;
    hole = slot;
    nxt = (hole + 1) % TABLE_SLOTS;
    for (int n = 0; n < TABLE_SLOTS && slot_live[nxt]; n++) begin
      home = slot_home(slot_tag[nxt]);
      d_home = (nxt + TABLE_SLOTS - home) % TABLE_SLOTS;
      d_hole = (nxt + TABLE_SLOTS - hole) % TABLE_SLOTS;
      if (d_home >= d_hole) begin
        slot_tag[hole]  = slot_tag[nxt];
        slot_refs[hole] = slot_refs[nxt];
        slot_live[hole] = 1'b1;
        hole = nxt;
      end
      nxt = (nxt + 1) % TABLE_SLOTS;
    end
    slot_live[hole] = 1'b0;
  endtask

  // Applies one accepted request to the shadow and queues the result it
  // must produce.
  task automatic account_request(input logic req, input logic [KEY_IN_BITS-1:0] key,
                                 input logic [LEN_BITS-1:0] len);
    acct_result_t r;
    int s;
    r.status = ST_IGNORED;
    r.step_request = 1'b0;
    r.step_work = '0;
    if (req == REQ_CHARGE) begin
      // The load check comes first, so even a known key is skipped near full.
      if ((live_count + 1) * 4 >= TABLE_SLOTS * 3) begin
        r.status = ST_FULL;
      end else begin
        s = locate(key);
        if (slot_live[s] && slot_tag[s] == key) begin
          if (slot_refs[s] != '1) slot_refs[s]++;
          r.status = ST_RAISED;
        end else begin
          slot_live[s] = 1'b1;
          slot_tag[s] = key;
          slot_refs[s] = 32'd1;
          live_count++;
          charged_sum += len;
          if (charged_sum > CHARGED_CAP) charged_sum = CHARGED_CAP;
          debt_sum += len;
          if (debt_sum > DEBT_CAP) debt_sum = DEBT_CAP;
          if (debt_sum >= step_threshold_now) begin
            r.step_request = 1'b1;
            r.step_work = WORK_W'(debt_sum >> WORK_SHIFT);
            debt_sum = 0;
          end
          r.status = ST_NEW;
        end
      end
    end else begin
      s = locate(key);
      if (slot_live[s] && slot_tag[s] == key) begin
        if (slot_refs[s] != 0) slot_refs[s]--;
        if (slot_refs[s] != 0) begin
          r.status = ST_LOWERED;
        end else begin
          // Credit the length back, but never below zero.
          if (live_count != 0) live_count--;
          charged_sum -= (len <= charged_sum) ? len : charged_sum;
          debt_sum -= (len <= debt_sum) ? len : debt_sum;
          evict(s);
          r.status = ST_REMOVED;
        end
      end
    end
    r.charged_total = CHARGED_W'(charged_sum);
    outcomes_due.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Random key whose home slot is the one asked for. Bits [11:4] alone select
  // the home, so the other 40 bits are free.
  function automatic logic [KEY_IN_BITS-1:0] key_at_home(input int home);
    logic [7:0]  kbits;
    logic [35:0] hi;
    logic [3:0]  lo;
    kbits = 8'(home * HOME_INVERSE);
    hi = 36'({$urandom(), $urandom()});
    lo = 4'($urandom());
    return {hi, kbits, lo};
  endfunction

  function automatic logic [LEN_BITS-1:0] pick_length();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return $urandom_range(65535);
      default: return $urandom();
    endcase
  endfunction

  task automatic plan_item(input logic req, input logic [KEY_IN_BITS-1:0] key,
                           input logic [LEN_BITS-1:0] len);
    plan_entry_t e;
    e.kind = PLAN_ITEM;
    e.req = req;
    e.key = key;
    e.len = len;
    e.value = '0;
    request_plan.push_back(e);
  endtask

  task automatic plan_control(input plan_kind_t kind, input logic [31:0] value);
    plan_entry_t e;
    e.kind = kind;
    e.req = REQ_CHARGE;
    e.key = '0;
    e.len = '0;
    e.value = value;
    request_plan.push_back(e);
  endtask

  // A share of the pool lands around the wrap point of the table, which
  // builds long clusters that cross from the last slot to the first.
  task automatic build_pool(input int count, input int cluster_pct);
    int home;
    key_pool.delete();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < cluster_pct) home = (252 + $urandom_range(7)) % TABLE_SLOTS;
      else home = $urandom_range(TABLE_SLOTS - 1);
      key_pool.push_back(key_at_home(home));
    end
  endtask

  // Mostly well-formed traffic on pool keys; the noise share discharges keys
  // that were almost surely never charged.
  task automatic plan_mix(input int count, input int charge_pct, input int noise_pct);
    int roll;
    logic [KEY_IN_BITS-1:0] stray;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < charge_pct) begin
        plan_item(REQ_CHARGE, key_pool[$urandom_range(key_pool.size() - 1)], pick_length());
      end else if (roll < charge_pct + noise_pct) begin
        stray = KEY_IN_BITS'({$urandom(), $urandom()});
        plan_item(REQ_DISCHARGE, stray, pick_length());
      end else begin
        plan_item(REQ_DISCHARGE, key_pool[$urandom_range(key_pool.size() - 1)], pick_length());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver. Request beats go out as the plan allows; threshold writes and
  // pauses wait until the block is idle with nothing outstanding.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      // The shadow takes each beat at the very edge the block does.
      if (start && !busy) begin
        account_request(req_type, block_key, block_length);
        beats_taken++;
      end
      if (cfg_valid && cfg_ready) step_threshold_now = cfg_data;

      hold_start = start && busy;
      hold_cfg = cfg_valid && !cfg_ready;

      if (!hold_start && !hold_cfg && request_plan.size() != 0) begin
        if (request_plan[0].kind == PLAN_ITEM) begin
          // Random gaps, except for one long stretch of back-to-back beats.
          // A gap starts rarely but holds for a random span, so about one ready
          // cycle in six goes idle.
          if (gap_left != 0) begin
            gap_left--;
          end else if (!(beats_taken >= 700 && beats_taken < 900) &&
                       $urandom_range(99) < 5) begin
            gap_left = $urandom_range(6);
          end else begin
            next_step = request_plan.pop_front();
            hold_start = 1'b1;
            req_type <= next_step.req;
            block_key <= next_step.key;
            block_length <= next_step.len;
          end
        end else if (outcomes_due.size() != 0 || busy || start) begin
          quiet_count = 0;
        end else if (quiet_count < QUIET_CYCLES) begin
          quiet_count++;
        end else begin
          quiet_count = 0;
          next_step = request_plan.pop_front();
          if (next_step.kind == PLAN_SET_THRESHOLD) begin
            hold_cfg = 1'b1;
            cfg_data <= next_step.value;
          end
        end
      end

      // One assignment per edge, so a start held across beats never dips.
      start <= hold_start;
      cfg_valid <= hold_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Results cannot be held off, so every done beat is checked
  // against the oldest outstanding prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        flag_mismatch("result beat with no request outstanding");
      end else begin
        want = outcomes_due.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (step_request !== want.step_request)
          flag_mismatch($sformatf("step_request got %b want %b", step_request,
                                  want.step_request));
        if (step_work !== want.step_work)
          flag_mismatch($sformatf("step_work got %h want %h", step_work, want.step_work));
        if (charged_total !== want.charged_total)
          flag_mismatch($sformatf("charged_total got %h want %h", charged_total,
                                  want.charged_total));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test plan and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [KEY_IN_BITS-1:0] key_lo;
    logic [KEY_IN_BITS-1:0] key_hi;
    logic [KEY_IN_BITS-1:0] wrap_a;
    logic [KEY_IN_BITS-1:0] wrap_b;
    logic [KEY_IN_BITS-1:0] wrap_c;
    logic [KEY_IN_BITS-1:0] after_wrap;

    key_lo = '0;
    key_hi = '1;
    wrap_a = key_at_home(TABLE_SLOTS - 1);
    wrap_b = key_at_home(TABLE_SLOTS - 1);
    wrap_c = key_at_home(TABLE_SLOTS - 1);
    after_wrap = key_at_home(0);

    // Directed part, at the reset threshold. An empty table ignores a
    // discharge; a zero-length new entry raises no step; a maximal length
    // triggers one with the largest step amount.
    plan_item(REQ_DISCHARGE, key_lo, '0);
    plan_item(REQ_CHARGE, key_lo, '0);
    plan_item(REQ_CHARGE, key_hi, '1);
    plan_item(REQ_CHARGE, key_lo, 32'd7);
    plan_item(REQ_DISCHARGE, key_lo, 32'd3);
    // Removal while the debt is zero clamps the debt, and a removal longer
    // than the charged total clamps the total to zero.
    plan_item(REQ_DISCHARGE, key_lo, 32'd5);
    plan_item(REQ_DISCHARGE, key_hi, '1);
    // Three keys homed on the last slot and one homed on slot zero build a
    // cluster across the wrap point; removals then shift entries backward.
    plan_item(REQ_CHARGE, wrap_a, 32'd1000);
    plan_item(REQ_CHARGE, wrap_b, 32'd1000);
    plan_item(REQ_CHARGE, wrap_c, 32'd1000);
    plan_item(REQ_CHARGE, after_wrap, 32'd1000);
    plan_item(REQ_DISCHARGE, wrap_a, 32'd1000);
    plan_item(REQ_DISCHARGE, key_at_home(TABLE_SLOTS - 1), 32'd1000);
    plan_item(REQ_CHARGE, wrap_b, 32'd1000);
    plan_item(REQ_DISCHARGE, wrap_c, 32'd1000);
    plan_item(REQ_DISCHARGE, wrap_b, 32'd1000);
    plan_item(REQ_DISCHARGE, wrap_b, 32'd1000);
    plan_item(REQ_DISCHARGE, after_wrap, 32'd1000);
    // Debt landing exactly on the threshold pays it.
    plan_item(REQ_CHARGE, key_at_home($urandom_range(TABLE_SLOTS - 1)), THRESHOLD_AT_RESET);
    plan_control(PLAN_HOLD, '0);

    // Threshold of one: nearly every new entry asks for a step.
    plan_control(PLAN_SET_THRESHOLD, 32'd1);
    build_pool(40, 30);
    plan_mix(250, 55, 5);

    // Highest threshold while the table fills up to the load limit, with a
    // full pause in the middle.
    plan_control(PLAN_SET_THRESHOLD, 32'hFFFF_FFFF);
    build_pool(240, 25);
    plan_mix(250, 90, 2);
    plan_control(PLAN_HOLD, '0);
    plan_mix(200, 90, 2);

    // Zero threshold while the table drains.
    plan_control(PLAN_SET_THRESHOLD, 32'd0);
    plan_mix(250, 15, 3);

    // A mid-range threshold on fresh keys.
    plan_control(PLAN_SET_THRESHOLD, $urandom_range(32'h0400_0000, 32'h0001_0000));
    build_pool(64, 40);
    plan_mix(330, 55, 5);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (request_plan.size() != 0 || start || cfg_valid || outcomes_due.size() != 0)
      @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every beat walking a long cluster
  // twice plus the longest sender gaps.
  initial begin : watchdog
    #80_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
